### rtl/efrc_pkg.sv
// Shared types, constants and helpers of the escaped frame receiver checker.
`default_nettype none
package efrc_pkg;

    localparam int COUNT_W = 16;
    localparam int LEN_W   = 16;
    localparam int CMP_W   = (COUNT_W > LEN_W) ? COUNT_W : LEN_W;
    localparam int ADDR_W  = 2;
    localparam int DATA_W  = 32;

    localparam logic [7:0]  CH_CR       = 8'h0D;
    localparam logic [7:0]  CH_LF       = 8'h0A;
    localparam logic [7:0]  CASE_BIT    = 8'h20;
    localparam logic [15:0] SUM_INIT    = 16'hFFFF;
    localparam logic [15:0] LEN_RESET   = 16'd256;
    localparam int          HDR_BYTES   = 4;
    localparam int          TYPE_IDX    = 5;
    localparam int          SEQ_HI_IDX  = 6;
    localparam int          SEQ_LO_IDX  = 7;
    localparam int          MIN_FRAME   = 8;

    localparam logic [ADDR_W-1:0] ADDR_MAX_LEN = '0;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_MISMATCH = 2'd1,
        ST_SHORT    = 2'd2
    } t_status;

    typedef struct packed {
        logic [15:0] computed_sum;
        logic [15:0] received_sum;
        logic [7:0]  sequence_res;
        logic [7:0]  msg_type;
    } t_result;

    // ASCII hex digit to nibble; case folded, non-hex digits give some nibble
    function automatic logic [3:0] hex_nibble(input logic [7:0] b);
        logic [7:0] c;
        logic [7:0] d;
        c = b & ~CASE_BIT;
        if (c >= 8'h41) begin
            d = c - 8'h41 + 8'd10;
        end else begin
            d = c - 8'h30;
        end
        return d[3:0];
    endfunction

endpackage
`default_nettype wire

### rtl/efrc_cfg.sv
// Register file of the frame receiver: APB access to the frame length limit.
`default_nettype none
module efrc_cfg
    import efrc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    output logic      [LEN_W-1:0]  o_max_len
);

    logic [LEN_W-1:0] r_max_len;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready && (paddr == ADDR_MAX_LEN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= LEN_RESET;
        end else if (wr_en) begin
            r_max_len <= pwdata[LEN_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr == ADDR_MAX_LEN) begin
            prdata = {{(DATA_W-LEN_W){1'b0}}, r_max_len};
        end
    end

    assign o_max_len = r_max_len;

endmodule
`default_nettype wire

### rtl/efrc_frame.sv
// Unescape and frame check state: one raw byte is processed per fire.
`default_nettype none
module efrc_frame
    import efrc_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_fire,
    input  wire logic [7:0]       i_byte,
    input  wire logic [LEN_W-1:0] i_max_len,
    output logic                  o_emit,
    output t_status               o_status,
    output t_result               o_result
);

    logic               r_esc,  n_esc;
    logic [COUNT_W-1:0] r_cnt,  n_cnt;
    logic [15:0]        r_sum,  n_sum;
    logic [15:0]        r_hdr,  n_hdr;
    logic [7:0]         r_type, n_type;
    logic [7:0]         r_seq,  n_seq;

    // state as seen after the length-limit restart
    logic               esc;
    logic [COUNT_W-1:0] cnt;
    logic [15:0]        sum;
    logic [15:0]        hdr;
    logic [7:0]         typ;
    logic [7:0]         seq;
    logic               limit_hit;
    logic               take;
    logic               restart;
    logic [3:0]         nib;

    assign limit_hit = CMP_W'(r_cnt) >= CMP_W'(i_max_len);
    assign nib       = hex_nibble(i_byte);

    always_comb begin
        esc = limit_hit ? 1'b0     : r_esc;
        cnt = limit_hit ? '0       : r_cnt;
        sum = limit_hit ? SUM_INIT : r_sum;
        hdr = limit_hit ? '0       : r_hdr;
        typ = limit_hit ? '0       : r_type;
        seq = limit_hit ? '0       : r_seq;

        take    = 1'b0;
        restart = 1'b0;
        o_emit  = 1'b0;
        n_esc   = 1'b0;
        if (!esc) begin
            if (i_byte == CH_CR) begin
                n_esc = 1'b1;
            end else begin
                take = 1'b1;
            end
        end else if (i_byte == CH_CR) begin
            take = 1'b1;            // escaped CR is a literal CR
        end else if (i_byte == CH_LF) begin
            o_emit  = 1'b1;
            restart = 1'b1;
        end else begin
            restart = 1'b1;         // bad escape drops the frame
        end

        n_cnt  = cnt;
        n_sum  = sum;
        n_hdr  = hdr;
        n_type = typ;
        n_seq  = seq;
        if (take) begin
            if (cnt < COUNT_W'(HDR_BYTES)) begin
                n_hdr = {hdr[11:0], nib};
            end else begin
                n_sum = sum + {8'd0, i_byte};
            end
            if (cnt == COUNT_W'(TYPE_IDX)) begin
                n_type = i_byte;
            end else if (cnt == COUNT_W'(SEQ_HI_IDX)) begin
                n_seq = {nib, 4'd0};
            end else if (cnt == COUNT_W'(SEQ_LO_IDX)) begin
                n_seq = {seq[7:4], nib};
            end
            n_cnt = cnt + 1'b1;
        end
        if (restart) begin
            n_cnt  = '0;
            n_sum  = SUM_INIT;
            n_hdr  = '0;
            n_type = '0;
            n_seq  = '0;
        end

        if (cnt < COUNT_W'(MIN_FRAME)) begin
            o_status = ST_SHORT;
        end else if (hdr != sum) begin
            o_status = ST_MISMATCH;
        end else begin
            o_status = ST_OK;
        end
        o_result.computed_sum = sum;
        o_result.received_sum = hdr;
        o_result.sequence_res = seq;
        o_result.msg_type     = typ;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc  <= 1'b0;
            r_cnt  <= '0;
            r_sum  <= SUM_INIT;
            r_hdr  <= '0;
            r_type <= '0;
            r_seq  <= '0;
        end else if (i_fire) begin
            r_esc  <= n_esc;
            r_cnt  <= n_cnt;
            r_sum  <= n_sum;
            r_hdr  <= n_hdr;
            r_type <= n_type;
            r_seq  <= n_seq;
        end
    end

endmodule
`default_nettype wire

### rtl/escaped_frame_receiver_checker_unit.sv
// Top level of the escaped frame receiver checker: channels, stage registers.
//
// Input channel (s_axis_*): one raw link byte per item. CR CR gives a literal
// CR, CR LF closes a frame, CR plus any other byte drops the frame silently.
// Output channel (m_axis_*): one item per closed frame carrying the status
// (tuser: ok, checksum mismatch, short frame) and the decoded header fields.
// APB port: register 0 at byte address 0 holds max_frame_len (reset 256);
// write it only while the block is idle.
//
// Pipeline: input register -> frame logic -> output register.
// Result: the result of a CR LF is loaded into the output register and shown
// on m_axis_tvalid at the edge at which the LF item leaves the input register.
// Throughput: one item per cycle while the output side does not stall; the
// frame state update (flag, counter, 16-bit add) is the only loop.
// Stall: when a result waits in the output register and m_axis_tready is
// low, the input register still takes one more item, then holds it and
// s_axis_tready drops until the result is taken.
// Reset (synchronous, active low): both stage registers empty, frame state
// cleared, running sum at 0xFFFF, limit back to 256.
`default_nettype none
module escaped_frame_receiver_checker_unit
    import efrc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // input channel
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic [7:0]        s_axis_tdata,   // [7:0] rx_byte
    // result channel
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic      [47:0]       m_axis_tdata,   // [7:0] msg_type, [15:8] sequence_res,
                                                   // [31:16] received_sum,
                                                   // [47:32] computed_sum
    output logic      [1:0]        m_axis_tuser,   // [1:0] frame_status
    // configuration
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready
);

    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_out_valid;
    t_result          r_out;
    t_status          r_out_status;

    logic             fire;
    logic             emit;
    t_status          status;
    t_result          result;
    logic [LEN_W-1:0] max_len;

    // the frame stage moves whenever the output register can take a result
    assign fire          = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || fire;

    efrc_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_max_len (max_len)
    );

    efrc_frame u_frame (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (fire),
        .i_byte    (r_in_byte),
        .i_max_len (max_len),
        .o_emit    (emit),
        .o_status  (status),
        .o_result  (result)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    // output register: a frame close loads a result, a taken result leaves
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= emit;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && emit) begin
            r_out        <= result;
            r_out_status <= status;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;
    assign m_axis_tuser  = r_out_status;

endmodule
`default_nettype wire

### rtl/efrc_checker.sv
// Port-level checks of the escaped frame receiver checker and their binding.
`default_nettype none
module efrc_checker
    import efrc_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              m_axis_tvalid,
    input wire logic              m_axis_tready,
    input wire logic [47:0]       m_axis_tdata,
    input wire logic [1:0]        m_axis_tuser,
    input wire logic              psel,
    input wire logic              penable,
    input wire logic              pwrite,
    input wire logic [ADDR_W-1:0] paddr,
    input wire logic [DATA_W-1:0] pwdata,
    input wire logic [DATA_W-1:0] prdata,
    input wire logic              pready
);

    // a stalled result holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("result changed while stalled");

    // status code three is never produced
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser != 2'd3))
        else $error("undefined frame status");

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // the length limit reads back what was written
    a_cfg_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite && pready && (paddr == ADDR_MAX_LEN)) |=>
            ((paddr != ADDR_MAX_LEN) || (prdata[LEN_W-1:0] == $past(pwdata[LEN_W-1:0]))))
        else $error("limit readback mismatch");

endmodule

bind escaped_frame_receiver_checker_unit efrc_checker u_efrc_checker (.*);
`default_nettype wire
